[design/ktmp_pkg.sv]
package ktmp_pkg;

    // Built defaults for the top-level parameters.
    localparam int MAX_TRANSACTIONS = 8;
    localparam int PRICE_BITS       = 16;

    // Configuration register: most transactions allowed.
    localparam int             CFG_W     = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd2;

    // Result field width and its saturation value.
    localparam int                  PROFIT_W   = 19;
    localparam logic [PROFIT_W-1:0] PROFIT_MAX = '1;

    // Control that every cell of the chain sees in the same cycle.
    typedef struct packed {
        logic en;     // a transaction was accepted, update the cell
        logic clear;  // the accepted price closes its series
    } t_cell_ctrl;

endpackage

[design/ktmp_if.sv]
// Price stream channel.
interface ktmp_in_if #(
    parameter int PRICE_BITS = ktmp_pkg::PRICE_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] price;
    logic                  last_day;

    modport source (output valid, output price, output last_day, input ready);
    modport sink   (input valid, input price, input last_day, output ready);
endinterface

// Result channel.
interface ktmp_out_if ();
    logic                           valid;
    logic                           ready;
    logic [ktmp_pkg::PROFIT_W-1:0]  best_profit;
    logic                           series_end;

    modport source (output valid, output best_profit, output series_end, input ready);
    modport sink   (input valid, input best_profit, input series_end, output ready);
endinterface

// Configuration write channel for the single register.
interface ktmp_cfg_if ();
    logic                        valid;
    logic                        ready;
    logic [ktmp_pkg::CFG_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/ktmp_cell.sv]
// One transaction count of the chain. The cell keeps the best cash while
// holding a share and while holding none, and takes the free value of its
// left neighbor from the previous price.
module ktmp_cell #(
    parameter int PRICE_BITS       = ktmp_pkg::PRICE_BITS,
    parameter int MAX_TRANSACTIONS = ktmp_pkg::MAX_TRANSACTIONS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ktmp_pkg::t_cell_ctrl  i_ctrl,
    input  logic [PRICE_BITS-1:0] i_price,
    input  logic [PRICE_BITS+$clog2(MAX_TRANSACTIONS+1)-1:0] i_free_prev,
    output logic [PRICE_BITS+$clog2(MAX_TRANSACTIONS+1)-1:0] o_free,
    output logic [PRICE_BITS+$clog2(MAX_TRANSACTIONS+1)-1:0] o_free_next
);

    localparam int FreeW = PRICE_BITS + $clog2(MAX_TRANSACTIONS + 1);
    localparam int HoldW = (PRICE_BITS + 5 > FreeW + 1) ? PRICE_BITS + 5 : FreeW + 1;
    localparam int SumW  = HoldW + 1;
    localparam logic signed [HoldW-1:0] HoldNone =
        HoldW'(-(64'sd1 <<< (PRICE_BITS + 4)));

    logic signed [HoldW-1:0] r_hold;
    logic signed [HoldW-1:0] n_hold;
    logic        [FreeW-1:0] r_free;
    logic        [FreeW-1:0] n_free;
    logic signed [SumW-1:0]  w_buy;
    logic signed [SumW-1:0]  w_sell;

    // Buy from the neighbor's free value, sell from this cell's holding.
    always_comb begin
        w_buy  = $signed(SumW'({1'b0, i_free_prev})) - $signed(SumW'({1'b0, i_price}));
        w_sell = SumW'(r_hold) + $signed(SumW'({1'b0, i_price}));
        n_hold = (w_buy > SumW'(r_hold)) ? HoldW'(w_buy) : r_hold;
        n_free = (w_sell > $signed(SumW'({1'b0, r_free}))) ? FreeW'(w_sell) : r_free;
    end

    // State update on each accepted transaction; cleared after the last price.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= HoldNone;
            r_free <= '0;
        end else if (i_ctrl.en) begin
            if (i_ctrl.clear) begin
                r_hold <= HoldNone;
                r_free <= '0;
            end else begin
                r_hold <= n_hold;
                r_free <= n_free;
            end
        end
    end

    assign o_free      = r_free;
    assign o_free_next = n_free;

endmodule

[design/k_transaction_max_profit_core.sv]
// Best profit from at most k buy-then-sell transactions over a price stream.
//
// Channels: i_in carries one price per transaction together with last_day.
// o_out returns one result per price: the best profit over the series so far
// and series_end, a copy of last_day. i_cfg writes max_transactions (k); it is
// always ready, to be written only while the block is idle, not enforced by the
// block. k of zero gives no profit; k above the cell count uses every cell.
//
// The result of an accepted price is registered in the output register. One
// price is accepted per cycle while the receiver is ready: a row of cells,
// one for each transaction count, updates every count in parallel, and each
// cell reads only its left neighbor's registered value, so no path spans the chain.
//
// Reset sets k to 2 and clears all cells to "no share held, no profit".
// The same clearing happens after the price marked last_day. While the
// receiver stalls, the result stays in the output register and i_in.ready
// is low until it is taken.
module k_transaction_max_profit_core #(
    parameter int MAX_TRANSACTIONS = ktmp_pkg::MAX_TRANSACTIONS,
    parameter int PRICE_BITS       = ktmp_pkg::PRICE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ktmp_in_if.sink       i_in,
    ktmp_cfg_if.sink      i_cfg,
    ktmp_out_if.source    o_out
);

    localparam int FreeW = PRICE_BITS + $clog2(MAX_TRANSACTIONS + 1);
    localparam int IdxW  = (MAX_TRANSACTIONS > 1) ? $clog2(MAX_TRANSACTIONS) : 1;

    // Maps a configured count onto the index of the cell that holds it.
    function automatic logic [IdxW-1:0] cell_of(input logic [ktmp_pkg::CFG_W-1:0] k);
        int kk;
        kk = int'(k);
        if (kk > MAX_TRANSACTIONS) begin
            kk = MAX_TRANSACTIONS;
        end
        return IdxW'(kk - 1);
    endfunction

    ktmp_pkg::t_cell_ctrl w_ctrl;
    logic                 w_accept;
    logic [FreeW-1:0]     w_free      [MAX_TRANSACTIONS];
    logic [FreeW-1:0]     w_free_next [MAX_TRANSACTIONS];
    logic [FreeW-1:0]     w_sel_free;
    logic [ktmp_pkg::PROFIT_W-1:0] n_best;

    logic                          r_k_zero;
    logic [IdxW-1:0]               r_k_sel;
    logic                          r_out_valid;
    logic [ktmp_pkg::PROFIT_W-1:0] r_best;
    logic                          r_end;

    // Handshakes: a new price enters when the output register is free or drains.
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_ctrl.en    = w_accept;
    assign w_ctrl.clear = i_in.last_day;

    // Chain of cells; the first cell buys from a free value of zero.
    for (genvar j = 0; j < MAX_TRANSACTIONS; j++) begin : g_cell
        logic [FreeW-1:0] w_left;
        if (j == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_body
            assign w_left = w_free[j-1];
        end
        ktmp_cell #(
            .PRICE_BITS       (PRICE_BITS),
            .MAX_TRANSACTIONS (MAX_TRANSACTIONS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_price     (i_in.price),
            .i_free_prev (w_left),
            .o_free      (w_free[j]),
            .o_free_next (w_free_next[j])
        );
    end

    // Pick the configured count's updated value and saturate to the field.
    always_comb begin
        w_sel_free = w_free_next[r_k_sel];
        if (r_k_zero) begin
            n_best = '0;
        end else if (64'(w_sel_free) > 64'(ktmp_pkg::PROFIT_MAX)) begin
            n_best = ktmp_pkg::PROFIT_MAX;
        end else begin
            n_best = ktmp_pkg::PROFIT_W'(w_sel_free);
        end
    end

    // Configuration register, kept as the selected cell and a zero flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_zero <= (ktmp_pkg::CFG_RESET == '0);
            r_k_sel  <= cell_of(ktmp_pkg::CFG_RESET);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_k_zero <= (i_cfg.data == '0);
            r_k_sel  <= cell_of(i_cfg.data);
        end
    end

    // Output register holding one result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_best <= n_best;
            r_end  <= i_in.last_day;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.best_profit = r_best;
    assign o_out.series_end  = r_end;

endmodule

[tb/k_transaction_max_profit_core_tb.sv]
`timescale 1ns / 100ps

module k_transaction_max_profit_core_tb;

    localparam int PRICE_BITS       = ktmp_pkg::PRICE_BITS;
    localparam int MAX_TRANSACTIONS = ktmp_pkg::MAX_TRANSACTIONS;
    localparam int PROFIT_W         = ktmp_pkg::PROFIT_W;
    localparam int CFG_W            = ktmp_pkg::CFG_W;

    localparam int HOLD_W      = PRICE_BITS + 5;
    localparam int FREE_W      = PRICE_BITS + 4;
    localparam int HOLD_NONE   = -(1 << (PRICE_BITS + 4));
    localparam int PRICE_TOP   = (1 << PRICE_BITS) - 1;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [PROFIT_W-1:0] best_profit;
        logic                series_end;
    } t_profit_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ktmp_in_if  in_if ();
    ktmp_cfg_if cfg_if ();
    ktmp_out_if out_if ();

    k_transaction_max_profit_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Predicted cell state and the configured transaction count.
    logic signed [HOLD_W-1:0] hold_cell [1:MAX_TRANSACTIONS];
    logic        [FREE_W-1:0] free_cell [1:MAX_TRANSACTIONS];
    logic        [CFG_W-1:0]  k_cfg;

    t_profit_result pending_profits [$];

    int         errors          = 0;
    int         results_checked = 0;
    int         prices_sent     = 0;
    int         series_closed   = 0;
    int         burst_left      = 0;
    int         cycle_count     = 0;
    logic [15:0] counts_used    = '0;

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Return every cell to "no share held, no profit".
    function automatic void clear_cells();
        for (int j = 1; j <= MAX_TRANSACTIONS; j++) begin
            hold_cell[j] = HOLD_W'(HOLD_NONE);
            free_cell[j] = '0;
        end
    endfunction

    // Advance all cells by one price and work out the running best profit.
    function automatic t_profit_result advance_cells(input logic [PRICE_BITS-1:0] price,
                                                     input logic last);
        int next_hold [1:MAX_TRANSACTIONS];
        int next_free [1:MAX_TRANSACTIONS];
        int buy_cash;
        int sell_cash;
        int eff_k;
        int best;
        t_profit_result res;
        for (int j = 1; j <= MAX_TRANSACTIONS; j++) begin
            buy_cash  = ((j == 1) ? 0 : int'(free_cell[j-1])) - int'(price);
            sell_cash = int'(hold_cell[j]) + int'(price);
            next_hold[j] = (buy_cash > int'(hold_cell[j])) ? buy_cash : int'(hold_cell[j]);
            next_free[j] = (sell_cash > int'(free_cell[j])) ? sell_cash : int'(free_cell[j]);
        end
        for (int j = 1; j <= MAX_TRANSACTIONS; j++) begin
            hold_cell[j] = next_hold[j][HOLD_W-1:0];
            free_cell[j] = next_free[j][FREE_W-1:0];
        end
        // A count above the built cells uses the top cell; zero gives no profit.
        eff_k = (int'(k_cfg) > MAX_TRANSACTIONS) ? MAX_TRANSACTIONS : int'(k_cfg);
        best  = (eff_k == 0) ? 0 : int'(free_cell[eff_k]);
        if (best < 0)
            best = 0;
        if (best > int'(ktmp_pkg::PROFIT_MAX))
            best = int'(ktmp_pkg::PROFIT_MAX);
        res.best_profit = best[PROFIT_W-1:0];
        res.series_end  = last;
        if (last)
            clear_cells();
        return res;
    endfunction

    // Send one price transaction, with random gaps between bursts.
    task automatic send_price(input logic [PRICE_BITS-1:0] price, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        in_if.valid    <= 1'b1;
        in_if.price    <= price;
        in_if.last_day <= last;
        do @(posedge i_clk); while (!in_if.ready);
        pending_profits.push_back(advance_cells(price, last));
        prices_sent++;
        if (last)
            series_closed++;
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_profits.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Write the transaction count while the block is idle.
    task automatic write_max_transactions(input logic [CFG_W-1:0] count);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= count;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        k_cfg = count;
        counts_used[count] = 1'b1;
    endtask

    // Pick the next price of a series according to its shape.
    function automatic logic [PRICE_BITS-1:0] next_price(input int shape,
                                                        input logic [PRICE_BITS-1:0] prev);
        int p;
        case (shape)
            0: p = $urandom_range(0, PRICE_TOP);
            1: begin
                p = int'(prev) + int'($urandom_range(0, 4000)) - 2000;
                if (p < 0)
                    p = 0;
                if (p > PRICE_TOP)
                    p = PRICE_TOP;
            end
            2: p = $urandom_range(0, 1) ? PRICE_TOP - $urandom_range(0, 3)
                                        : $urandom_range(0, 3);
            default: p = $urandom_range(0, 15);
        endcase
        return p[PRICE_BITS-1:0];
    endfunction

    // Send one series of prices; an open series leaves last_day low at its end.
    task automatic send_series(input int length, input logic close_it);
        int shape;
        logic [PRICE_BITS-1:0] price;
        shape = $urandom_range(0, 3);
        price = PRICE_BITS'($urandom_range(0, PRICE_TOP));
        for (int n = 0; n < length; n++) begin
            price = next_price(shape, price);
            send_price(price, close_it && (n == length - 1));
        end
    endtask

    // Receiver with its own stall pattern, switching among random stall modes.
    initial begin
        int stall_mode;
        int rx_cycle;
        stall_mode = 0;
        rx_cycle   = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (rx_cycle % 128 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= 1'($urandom_range(0, 1));
                2: out_if.ready <= (rx_cycle % 5) != 0;
                default: out_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_profit_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_profits.size() == 0) begin
                errors++;
                $display("%0t: unexpected result best_profit %0d series_end %0b",
                         $time, out_if.best_profit, out_if.series_end);
            end else begin
                want = pending_profits.pop_front();
                results_checked++;
                if (out_if.best_profit !== want.best_profit) begin
                    errors++;
                    $display("%0t: best_profit mismatch expected %0d actual %0d",
                             $time, want.best_profit, out_if.best_profit);
                end
                if (out_if.series_end !== want.series_end) begin
                    errors++;
                    $display("%0t: series_end mismatch expected %0b actual %0b",
                             $time, want.series_end, out_if.series_end);
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_profits.size());
            $display("status: fail");
            $finish;
        end
    end

    // Reset count of two, classic small series, then a single-day series.
    task automatic test_default_count();
        send_price(16'd7, 1'b0);
        send_price(16'd1, 1'b0);
        send_price(16'd5, 1'b0);
        send_price(16'd3, 1'b0);
        send_price(16'd6, 1'b1);
        send_price(16'd100, 1'b1);
    endtask

    // Alternating zero and full-scale prices with all cells in use, then with a count of one.
    task automatic test_price_extremes();
        write_max_transactions(4'd8);
        for (int n = 0; n < 6; n++)
            send_price((n % 2 == 0) ? '0 : '1, n == 5);
        write_max_transactions(4'd1);
        send_price('1, 1'b0);
        send_price('0, 1'b1);
    endtask

    // A count of zero never reports a profit.
    task automatic test_zero_transactions();
        write_max_transactions(4'd0);
        send_price(16'd10, 1'b0);
        send_price(16'd20, 1'b1);
    endtask

    // Counts above the built cells behave as the top cell.
    task automatic test_count_saturation();
        write_max_transactions(4'd15);
        send_price(16'd1, 1'b0);
        send_price(16'd9, 1'b0);
        send_price(16'd2, 1'b0);
        send_price(16'd9, 1'b1);
    endtask

    // Changing the count in the middle of a series reads the new cell.
    task automatic test_count_change_mid_series();
        write_max_transactions(4'd3);
        send_price(16'd3, 1'b0);
        send_price(16'd8, 1'b0);
        send_price(16'd1, 1'b0);
        write_max_transactions(4'd1);
        send_price(16'd9, 1'b0);
        send_price(16'd2, 1'b1);
    endtask

    // Random series under a sweep of counts 1 to 8, then 0, 15 and 9, then random counts.
    task automatic test_random_series();
        int target;
        int phase;
        int n_series;
        int length;
        logic [CFG_W-1:0] count;
        target = prices_sent + RANDOM_ITEMS;
        phase  = 0;
        while (prices_sent < target) begin
            if (phase < 11)
                count = CFG_W'((phase < 8) ? phase + 1
                                           : ((phase == 8) ? 0 : ((phase == 9) ? 15 : 9)));
            else
                count = CFG_W'($urandom_range(0, 15));
            write_max_transactions(count);
            n_series = $urandom_range(2, 5);
            for (int s = 0; s < n_series; s++) begin
                length = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 20);
                // Sometimes leave the last series open across the count change.
                send_series(length, !((s == n_series - 1) && ($urandom_range(0, 3) == 0)));
            end
            phase++;
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.price    <= '0;
        in_if.last_day <= 1'b0;
        cfg_if.valid   <= 1'b0;
        cfg_if.data    <= '0;
        clear_cells();
        k_cfg = ktmp_pkg::CFG_RESET;
        counts_used[ktmp_pkg::CFG_RESET] = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_count();
        test_price_extremes();
        test_zero_transactions();
        test_count_saturation();
        test_count_change_mid_series();
        test_random_series();

        drain_results();
        repeat (4) @(posedge i_clk);

        $display("Checked %0d results from %0d prices over %0d closed series.",
                 results_checked, prices_sent, series_closed);
        $display("Transaction counts exercised (bit per count 15..0): %b", counts_used);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
